/* rtl/core/cblt_pkg.sv */
`default_nettype none

package cblt_pkg;

  localparam int ENT_W   = 8;
  localparam int COORD_W = 6;
  localparam int STAT_W  = 2;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_RANGE   = 2'd1;
  localparam status_t STATUS_MISSING = 2'd2;

  localparam logic FUNC_PLACE  = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // End-of-list marker held in head and link entries
  localparam logic [ENT_W-1:0] LINK_EMPTY = 8'hFF;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic    vld;
    status_t status;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/cblt_ram.sv */
`default_nettype none

module cblt_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/cblt_walk.sv */
`default_nettype none

module cblt_walk #(
  parameter int ENTITY_COUNT = 128,
  parameter int GRID_WIDTH   = 64,
  parameter int GRID_HEIGHT  = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_func,
  input  wire logic [cblt_pkg::ENT_W-1:0]   in_entity_id,
  input  wire logic [cblt_pkg::COORD_W-1:0] in_cell_x,
  input  wire logic [cblt_pkg::COORD_W-1:0] in_cell_y,
  output cblt_pkg::res_t                    res,
  input  wire logic                         res_ack
);

  localparam int CELL_TOTAL = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_AW    = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
  localparam int ENT_AW     = $clog2(ENTITY_COUNT);
  localparam int STEP_W     = $clog2(ENTITY_COUNT + 1);
  localparam int CW         = cblt_pkg::COORD_W;
  localparam int EW         = cblt_pkg::ENT_W;
  localparam int MW         = 2 * CW + 1;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PLC_RD  = 4'd2;
  localparam logic [3:0] S_CIDX    = 4'd3;
  localparam logic [3:0] S_HEAD_RD = 4'd4;
  localparam logic [3:0] S_HEAD_WT = 4'd5;
  localparam logic [3:0] S_CHECK   = 4'd6;
  localparam logic [3:0] S_LINK_WT = 4'd7;
  localparam logic [3:0] S_UNLINK  = 4'd8;
  localparam logic [3:0] S_RESULT  = 4'd9;

  logic [3:0]              state_r, state_nxt;
  logic [CELL_AW-1:0]      clr_r, clr_nxt;
  logic                    func_r, func_nxt;
  logic [EW-1:0]           ent_r, ent_nxt;
  logic [CW-1:0]           x_r, x_nxt, y_r, y_nxt;
  logic [CELL_AW-1:0]      c_r, c_nxt;
  logic [EW-1:0]           cur_r, cur_nxt;
  logic [EW-1:0]           prev_r, prev_nxt;
  logic                    has_prev_r, has_prev_nxt;
  logic [STEP_W-1:0]       steps_r, steps_nxt;
  cblt_pkg::status_t       st_r, st_nxt;
  logic [ENTITY_COUNT-1:0] placed_r, placed_nxt;

  logic [CW-1:0]      x_sat, y_sat;
  logic [MW-1:0]      cidx_full;
  logic               in_range;
  logic               found;

  logic               head_we;
  logic [CELL_AW-1:0] head_waddr;
  logic [EW-1:0]      head_wdata;
  logic [EW-1:0]      head_q;
  logic               link_we;
  logic [ENT_AW-1:0]  link_waddr;
  logic [EW-1:0]      link_wdata;
  logic [EW-1:0]      link_q;
  logic               plc_we;
  logic [2*CW-1:0]    plc_q;

  // Clamp the requested cell onto the grid
  assign x_sat = ({1'b0, in_cell_x} >= (CW+1)'(GRID_WIDTH))  ? CW'(GRID_WIDTH - 1)  : in_cell_x;
  assign y_sat = ({1'b0, in_cell_y} >= (CW+1)'(GRID_HEIGHT)) ? CW'(GRID_HEIGHT - 1) : in_cell_y;

  assign cidx_full = MW'(x_r) * MW'(GRID_HEIGHT) + MW'(y_r);
  assign in_range  = in_entity_id < EW'(ENTITY_COUNT);
  assign found     = cur_r == ent_r;

  assign in_ready   = state_r == S_IDLE;
  assign res.vld    = state_r == S_RESULT;
  assign res.status = st_r;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    func_nxt     = func_r;
    ent_nxt      = ent_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    c_nxt        = c_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    has_prev_nxt = has_prev_r;
    steps_nxt    = steps_r;
    st_nxt       = st_r;
    placed_nxt   = placed_r;
    head_we      = 1'b0;
    head_waddr   = c_r;
    head_wdata   = link_q;
    link_we      = 1'b0;
    link_waddr   = ent_r[ENT_AW-1:0];
    link_wdata   = cblt_pkg::LINK_EMPTY;
    plc_we       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        head_wdata = cblt_pkg::LINK_EMPTY;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CELL_AW'(CELL_TOTAL - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          ent_nxt  = in_entity_id;
          x_nxt    = x_sat;
          y_nxt    = y_sat;
          if (!in_range) begin
            st_nxt    = cblt_pkg::STATUS_RANGE;
            state_nxt = S_RESULT;
          end else if (in_func == cblt_pkg::FUNC_PLACE) begin
            state_nxt = S_CIDX;
          end else if (!placed_r[in_entity_id[ENT_AW-1:0]]) begin
            st_nxt    = cblt_pkg::STATUS_MISSING;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_PLC_RD;
          end
        end
      end
      S_PLC_RD: begin
        x_nxt     = plc_q[2*CW-1:CW];
        y_nxt     = plc_q[CW-1:0];
        state_nxt = S_CIDX;
      end
      S_CIDX: begin
        c_nxt     = cidx_full[CELL_AW-1:0];
        state_nxt = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        state_nxt = S_HEAD_WT;
      end
      S_HEAD_WT: begin
        if (func_r == cblt_pkg::FUNC_PLACE) begin
          // Push onto the head of the cell's list
          head_we    = 1'b1;
          head_wdata = ent_r;
          link_we    = 1'b1;
          link_wdata = head_q;
          plc_we     = 1'b1;
          placed_nxt[ent_r[ENT_AW-1:0]] = 1'b1;
          st_nxt     = cblt_pkg::STATUS_OK;
          state_nxt  = S_RESULT;
        end else begin
          cur_nxt      = head_q;
          has_prev_nxt = 1'b0;
          steps_nxt    = '0;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (steps_r == STEP_W'(ENTITY_COUNT) || cur_r >= EW'(ENTITY_COUNT)) begin
          st_nxt    = cblt_pkg::STATUS_MISSING;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_LINK_WT;
        end
      end
      S_LINK_WT: begin
        if (found) begin
          // Splice the entity out: fix the predecessor or the head
          if (has_prev_r) begin
            link_we    = 1'b1;
            link_waddr = prev_r[ENT_AW-1:0];
            link_wdata = link_q;
          end else begin
            head_we = 1'b1;
          end
          state_nxt = S_UNLINK;
        end else begin
          prev_nxt     = cur_r;
          cur_nxt      = link_q;
          has_prev_nxt = 1'b1;
          steps_nxt    = steps_r + 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_UNLINK: begin
        link_we    = 1'b1;
        link_wdata = cblt_pkg::LINK_EMPTY;
        placed_nxt[ent_r[ENT_AW-1:0]] = 1'b0;
        st_nxt     = cblt_pkg::STATUS_OK;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      placed_r <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      placed_r <= placed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    ent_r      <= ent_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    c_r        <= c_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    has_prev_r <= has_prev_nxt;
    steps_r    <= steps_nxt;
    st_r       <= st_nxt;
  end

  cblt_ram #(.DEPTH(CELL_TOTAL), .AW(CELL_AW), .DW(EW)) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (c_r),
    .rdata (head_q)
  );

  cblt_ram #(.DEPTH(ENTITY_COUNT), .AW(ENT_AW), .DW(EW)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (cur_r[ENT_AW-1:0]),
    .rdata (link_q)
  );

  cblt_ram #(.DEPTH(ENTITY_COUNT), .AW(ENT_AW), .DW(2*CW)) u_plc (
    .clk   (clk),
    .we    (plc_we),
    .waddr (ent_r[ENT_AW-1:0]),
    .wdata ({x_r, y_r}),
    .raddr (in_entity_id[ENT_AW-1:0]),
    .rdata (plc_q)
  );

endmodule

`default_nettype wire

/* rtl/core/cell_bucket_list_table_top.sv */
// Cell bucket list table: one singly linked list of entity numbers per grid cell.
// Input channel (in_valid/in_ready): one word per request. in_func selects place
// (push in_entity_id onto the list of cell in_cell_x/in_cell_y, coordinates
// clamped to the grid) or remove (unlink the entity from the cell it was placed in).
// Result channel (out_valid/out_ready): exactly one word per request, out_status
// 0 ok, 1 entity number out of range, 2 entity not placed or not in its list.
// One request is in flight at a time; in_ready is low until its result word has
// been moved into the output register. Out-of-range requests and removes of an
// unplaced entity go straight to the result; a remove walks the cell's list from
// its head, and each link visited costs one read of the link RAM and one compare
// in the walk sequencer.
// The output register holds a word while out_ready is low, and the next request
// is still taken meanwhile; its result waits in the sequencer until the register
// frees up.
// Reset (rst_n low, synchronous) clears all placements, then a clearing pass
// writes the empty marker into all GRID_WIDTH*GRID_HEIGHT head entries (4096 by
// default), one per cycle, with in_ready held low.
`default_nettype none

module cell_bucket_list_table_top #(
  parameter int ENTITY_COUNT = 128,
  parameter int GRID_WIDTH   = 64,
  parameter int GRID_HEIGHT  = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_func,
  input  wire logic [cblt_pkg::ENT_W-1:0]   in_entity_id,
  input  wire logic [cblt_pkg::COORD_W-1:0] in_cell_x,
  input  wire logic [cblt_pkg::COORD_W-1:0] in_cell_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [cblt_pkg::STAT_W-1:0]       out_status
);

  cblt_pkg::res_t    res;
  logic              res_ack;
  logic              out_valid_r, out_valid_nxt;
  cblt_pkg::status_t out_status_r, out_status_nxt;

  cblt_walk #(
    .ENTITY_COUNT (ENTITY_COUNT),
    .GRID_WIDTH   (GRID_WIDTH),
    .GRID_HEIGHT  (GRID_HEIGHT)
  ) u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_entity_id (in_entity_id),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .res          (res),
    .res_ack      (res_ack)
  );

  // Load a new word whenever the output register is empty or being drained
  assign res_ack = res.vld && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    if (res_ack) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res.status;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

/* rtl/core/cblt_chk.sv */
`default_nettype none

module cblt_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result word changed or dropped under stall");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // One request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // Head clearing pass follows reset
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("ready before head clearing pass");

endmodule

bind cell_bucket_list_table_top cblt_chk u_cblt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status)
);

`default_nettype wire
